// ===== rtl/core/pesm_pkg.sv =====
// Shared constants, types and state codes for the proximity eye scale smoother.
package pesm_pkg;

	// Field widths.
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned PS_W    = 11;
	localparam int unsigned SCALE_W = 16;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned CIDX_W  = 3;
	localparam int unsigned IN_W    = 48;
	localparam int unsigned OUT_W   = 32;

	// Divider sizing: the product of an 11-bit offset and a span of at most 32768.
	localparam int unsigned DIV_W   = 26;
	localparam int unsigned DCNT_W  = 5;
	localparam logic [DCNT_W-1:0] DIV_STEPS = 5'd26;

	// Timing and scale constants.
	localparam logic [TIME_W-1:0]  READ_INTERVAL_MS = 32'd120;
	localparam logic [TIME_W-1:0]  SURPRISE_COOL_MS = 32'd4000;
	localparam logic [SCALE_W-1:0] SCALE_ONE        = 16'd16384;
	localparam logic [SCALE_W-1:0] SCALE_MAX_LIMIT  = 16'd49152;
	localparam logic [14:0]        GAIN_GROW        = 15'd29491;
	localparam logic [14:0]        GAIN_SHRINK      = 15'd9830;
	localparam logic [SCALE_W-1:0] SNAP_DIST        = 16'd164;
	localparam logic [PS_W-1:0]    PS_LIMIT         = 11'd2047;
	localparam logic [PS_W:0]      VN_MARGIN        = 12'd50;
	localparam logic [31:0]        ROUND_HALF       = 32'd32768;

	// Register indexes on the configuration port.
	localparam logic [CIDX_W-1:0] CFG_SENSOR_PRESENT = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_ENABLED        = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_NEAR_THRESH    = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_VNEAR_THRESH   = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_MAX_SCALE      = 3'd4;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GATE,
		ST_MUL,
		ST_DIV,
		ST_SMOOTH,
		ST_SNAP,
		ST_EMIT
	} pesm_state_t;

	// Divider response towards the sequencer.
	typedef struct packed {
		logic               done;
		logic [SCALE_W-1:0] quot;
	} pesm_div_rsp_t;

endpackage

// ===== rtl/core/proximity_eye_scale_smoother.sv =====
// Top level of the proximity eye scale smoother: sequencer, state and stream ports.
//
// Channel   Role    Transaction content (lowest bit first)
// s_*       input   now_ms[31:0], ps_sample[42:32], bus_busy[43], zero [47:44]
// m_*       output  sampled[0], scale_updated[1], eye_scale[17:2], surprise[18],
//                   last_raw[29:19], zero [31:30]
// cfg_*     write   cfg_we, cfg_index (register number), cfg_data
//
// A gated or disabled poll goes from the gate check straight to the output register.
// A poll above the near threshold that needs the ratio passes through the 26 steps of
// the shared restoring divider before smoothing; others go from the gate check to smoothing.
// One poll is handled at a time; s_tready is high only while the sequencer is idle.
// The output register holds one result, so a new poll is taken while it waits.
// arst_n clears the sequencer, the output valid flag and all model state at once.
module proximity_eye_scale_smoother (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [pesm_pkg::IN_W-1:0]      s_tdata,  // now_ms, ps_sample, bus_busy
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [pesm_pkg::OUT_W-1:0]     m_tdata,  // sampled, scale_updated, eye_scale,
	                                                 // surprise, last_raw
	input  logic                           cfg_we,
	input  logic [pesm_pkg::CIDX_W-1:0]    cfg_index,
	input  logic [pesm_pkg::CFG_W-1:0]     cfg_data
);
	import pesm_pkg::*;

	pesm_state_t state_q, state_d;

	// Configuration registers.
	logic               sensor_q;
	logic               enabled_q;
	logic [PS_W-1:0]    near_q;
	logic [PS_W-1:0]    vnear_q;
	logic [SCALE_W-1:0] maxs_q;

	// Model state.
	logic [TIME_W-1:0]  last_read_q;
	logic [TIME_W-1:0]  last_surp_q;
	logic [SCALE_W-1:0] cur_q;
	logic               was_vn_q;
	logic [PS_W-1:0]    raw_q;

	// Captured poll and working values.
	logic [TIME_W-1:0]  now_q;
	logic [PS_W-1:0]    ps_q;
	logic               busy_q;
	logic [SCALE_W-1:0] target_q;
	logic [SCALE_W-1:0] step_q;
	logic               grow_q;
	logic               sampled_q;
	logic               upd_q;
	logic               surp_q;

	// Output register.
	logic               m_valid_q;
	logic [OUT_W-1:0]   m_data_q;

	// Sequencer outputs.
	logic               in_take;
	logic               div_start;
	logic               out_load;

	// Clamped thresholds and derived quantities.
	logic [PS_W:0]      vn_wide;
	logic [PS_W-1:0]    vn_c;
	logic [SCALE_W-1:0] maxs_c;
	logic [SCALE_W-1:0] span;
	logic [PS_W-1:0]    d_off;
	logic [PS_W-1:0]    r_rng;
	logic               above_near;
	logic               sat_max;
	logic               gated;
	logic               very;
	logic               surp_fire;
	logic [PS_W+SCALE_W-1:0] mul_prod;
	pesm_div_rsp_t      div_rsp;

	// Smoothing path.
	logic               grow;
	logic [SCALE_W-1:0] diff;
	logic [30:0]        smooth_prod;
	logic [31:0]        smooth_sum;
	logic [SCALE_W-1:0] new_cur;
	logic [SCALE_W-1:0] snap_gap;

	// Threshold clamping on use and the gate checks.
	always_comb begin
		vn_wide = {1'b0, vnear_q};
		if (vnear_q <= near_q) begin
			vn_wide = {1'b0, near_q} + VN_MARGIN;
		end
		vn_c = (vn_wide > {1'b0, PS_LIMIT}) ? PS_LIMIT : vn_wide[PS_W-1:0];
		if (maxs_q < SCALE_ONE) begin
			maxs_c = SCALE_ONE;
		end else if (maxs_q > SCALE_MAX_LIMIT) begin
			maxs_c = SCALE_MAX_LIMIT;
		end else begin
			maxs_c = maxs_q;
		end
		span       = maxs_c - SCALE_ONE;
		above_near = ps_q > near_q;
		d_off      = ps_q - near_q;
		r_rng      = vn_c - near_q;
		sat_max    = (r_rng == '0) || (d_off >= r_rng);
		gated      = !sensor_q || busy_q || ((now_q - last_read_q) < READ_INTERVAL_MS);
		very       = ps_q >= vn_c;
		surp_fire  = very && !was_vn_q && ((now_q - last_surp_q) > SURPRISE_COOL_MS);
		mul_prod   = d_off * span;
	end

	// Smoothing step and snap arithmetic.
	always_comb begin
		grow        = target_q > cur_q;
		diff        = grow ? (target_q - cur_q) : (cur_q - target_q);
		smooth_prod = diff * (grow ? GAIN_GROW : GAIN_SHRINK);
		smooth_sum  = {1'b0, smooth_prod} + ROUND_HALF;
		new_cur     = grow_q ? (cur_q + step_q) : (cur_q - step_q);
		snap_gap    = (new_cur > target_q) ? (new_cur - target_q) : (target_q - new_cur);
	end

	// Shared divider for the linear mapping ratio.
	pesm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mul_prod[DIV_W-1:0]),
		.divisor  (r_rng),
		.rsp      (div_rsp)
	);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_GATE;
			end
			ST_GATE: begin
				if (gated || !enabled_q) begin
					state_d = ST_EMIT;
				end else if (above_near && !sat_max) begin
					state_d = ST_MUL;
				end else begin
					state_d = ST_SMOOTH;
				end
			end
			ST_MUL: state_d = ST_DIV;
			ST_DIV: begin
				if (div_rsp.done) state_d = ST_SMOOTH;
			end
			ST_SMOOTH: state_d = ST_SNAP;
			ST_SNAP: state_d = ST_EMIT;
			ST_EMIT: begin
				if (!m_valid_q || m_tready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer control outputs.
	always_comb begin
		in_take   = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: in_take   = s_tvalid;
			ST_MUL:  div_start = 1'b1;
			ST_EMIT: out_load  = !m_valid_q || m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_q  <= 1'b0;
			enabled_q <= 1'b1;
			near_q    <= 11'd150;
			vnear_q   <= 11'd600;
			maxs_q    <= 16'd26214;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SENSOR_PRESENT: sensor_q  <= cfg_data[0];
				CFG_ENABLED:        enabled_q <= cfg_data[0];
				CFG_NEAR_THRESH:    near_q    <= cfg_data[PS_W-1:0];
				CFG_VNEAR_THRESH:   vnear_q   <= cfg_data[PS_W-1:0];
				CFG_MAX_SCALE:      maxs_q    <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// Model state updates along the sequence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_read_q <= '0;
			last_surp_q <= '0;
			cur_q       <= SCALE_ONE;
			was_vn_q    <= 1'b0;
			raw_q       <= '0;
			sampled_q   <= 1'b0;
			upd_q       <= 1'b0;
			surp_q      <= 1'b0;
		end else begin
			case (state_q)
				ST_GATE: begin
					sampled_q <= !gated;
					upd_q     <= 1'b0;
					surp_q    <= 1'b0;
					if (!gated) begin
						last_read_q <= now_q;
						if (!enabled_q) begin
							upd_q    <= cur_q != SCALE_ONE;
							cur_q    <= SCALE_ONE;
							was_vn_q <= 1'b0;
						end else begin
							upd_q    <= 1'b1;
							raw_q    <= ps_q;
							was_vn_q <= very;
							if (surp_fire) begin
								surp_q      <= 1'b1;
								last_surp_q <= now_q;
							end
						end
					end
				end
				ST_SNAP: cur_q <= (snap_gap < SNAP_DIST) ? target_q : new_cur;
				default: ;
			endcase
		end
	end

	// Poll capture and working payload registers.
	always_ff @(posedge clk) begin
		if (in_take) begin
			now_q  <= s_tdata[TIME_W-1:0];
			ps_q   <= s_tdata[TIME_W +: PS_W];
			busy_q <= s_tdata[TIME_W+PS_W];
		end
		case (state_q)
			ST_GATE: target_q <= !above_near ? SCALE_ONE : maxs_c;
			ST_DIV: begin
				if (div_rsp.done) target_q <= SCALE_ONE + div_rsp.quot;
			end
			ST_SMOOTH: begin
				step_q <= smooth_sum[31:16];
				grow_q <= grow;
			end
			default: ;
		endcase
	end

	// Output register separating the result from the downstream stall.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= {2'b00, raw_q, surp_q, cur_q, upd_q, sampled_q};
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

// ===== rtl/core/pesm_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module pesm_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [pesm_pkg::DIV_W-1:0]   dividend,
	input  logic [pesm_pkg::PS_W-1:0]    divisor,
	output pesm_pkg::pesm_div_rsp_t      rsp
);
	import pesm_pkg::*;

	logic [DCNT_W-1:0] count_q;
	logic              done_q;
	logic [DIV_W-1:0]  work_q;
	logic [PS_W-1:0]   rem_q;
	logic [PS_W-1:0]   dvs_q;
	logic [PS_W+1:0]   trial;
	logic              qbit;
	logic [PS_W-1:0]   rem_next;

	// Trial subtraction of the divisor from the shifted partial remainder.
	always_comb begin
		trial    = {1'b0, rem_q, work_q[DIV_W-1]} - {2'b00, dvs_q};
		qbit     = ~trial[PS_W+1];
		rem_next = qbit ? trial[PS_W-1:0] : {rem_q[PS_W-2:0], work_q[DIV_W-1]};
	end

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				count_q <= DIV_STEPS;
			end else if (count_q != '0) begin
				count_q <= count_q - 1'b1;
				if (count_q == DCNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// Working registers: the dividend shifts out as the quotient shifts in.
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (count_q != '0) begin
			work_q <= {work_q[DIV_W-2:0], qbit};
			rem_q  <= rem_next;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = work_q[SCALE_W-1:0];

endmodule
